// File: rtl/rcpu_pkg.sv
// ----------------------------------------------------------------------------
// rcpu_pkg
// Shared constants, types and helpers of the RCP rate update core.
// ----------------------------------------------------------------------------
package rcpu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SUM_WIDTH = 48;

  // Datapath word of the serial units and the working registers.
  localparam int QW    = 64;
  localparam int SH_W  = 6;
  localparam int CNT_W = 7;

  // Field widths.
  localparam int SUM_FIELD_W = 48;
  localparam int CNT_FIELD_W = 32;
  localparam int BYTES_W     = 48;
  localparam int QLEN_W      = 32;
  localparam int RATE_W      = 20;
  localparam int CLIP_W      = 2;
  localparam int INTERVAL_W  = 24;
  localparam int AVG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [QW-1:0] QMAX     = 64'h4000_0000_0000_0000;
  localparam logic [QW-1:0] ONE      = 64'd1 << FRAC_BITS;
  localparam logic [QW-1:0] SUM_MASK = (~64'd0) >> (QW - SUM_WIDTH);
  localparam logic [QW-1:0] M32      = 64'hFFFF_FFFF;
  localparam logic [QW-1:0] M24      = 64'hFF_FFFF;
  localparam logic [QW-1:0] M20      = 64'hF_FFFF;
  localparam logic [QW-1:0] FAC_LIM  = QMAX >> 20;

  // Reset values of the running state.
  localparam logic [QW-1:0] AVG_RESET_W = 64'd200 << FRAC_BITS;
  localparam logic [QW-1:0] INT_RESET_W = 64'd10 << FRAC_BITS;
  localparam logic [AVG_W-1:0]      AVG_RESET  = AVG_RESET_W[AVG_W-1:0];
  localparam logic [RATE_W-1:0]     RATE_RESET = 20'd6250;
  localparam logic [INTERVAL_W-1:0] INT_RESET  =
      (INT_RESET_W > M24) ? M24[INTERVAL_W-1:0] : INT_RESET_W[INTERVAL_W-1:0];

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK_CAPACITY = 3'd0,
    CFG_ALPHA_GAIN    = 3'd1,
    CFG_BETA_GAIN     = 3'd2,
    CFG_GAMMA_GAIN    = 3'd3,
    CFG_MIN_PKTS      = 3'd4,
    CFG_PACKET_SIZE   = 3'd5,
    CFG_TIMESLOT_MS   = 3'd6
  } cfg_idx_t;

  typedef enum logic [CLIP_W-1:0] {
    CLIP_LOW  = 2'd0,
    CLIP_HIGH = 2'd1,
    CLIP_NONE = 2'd2
  } clip_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MEAN, ST_R3, ST_R1, ST_R2, ST_G1, ST_G2, ST_A1, ST_A2,
    ST_VCAP, ST_D, ST_QA, ST_TA, ST_EA, ST_EB, ST_P, ST_X, ST_TEMP,
    ST_MP, ST_MINR, ST_OUT
  } state_t;

  typedef struct packed {
    logic [19:0] link_capacity;
    logic [15:0] alpha_gain;
    logic [15:0] beta_gain;
    logic [15:0] gamma_gain;
    logic [23:0] min_pkts_per_rtt;
    logic [15:0] packet_size;
    logic [7:0]  timeslot_ms;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [QW-1:0]   num;
    logic [QW-1:0]   den;
    logic [SH_W-1:0] sh;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic          start;
    logic [QW-1:0] x;
    logic [QW-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic            done;
    logic [2*QW-1:0] prod;
  } mul_rsp_t;

  // min(p >> sh, QMAX)
  function automatic logic [QW-1:0] sat_shr(input logic [2*QW-1:0] p,
                                            input int unsigned sh);
    logic [2*QW-1:0] s;
    s = p >> sh;
    return (s > {{QW{1'b0}}, QMAX}) ? QMAX : s[QW-1:0];
  endfunction

  // min(v, 1.0)
  function automatic logic [FRAC_BITS:0] cap1(input logic [QW-1:0] v);
    return (v > ONE) ? ONE[FRAC_BITS:0] : v[FRAC_BITS:0];
  endfunction

endpackage

// File: rtl/rcpu_if.sv
// ----------------------------------------------------------------------------
// rcpu_if
// Channel interfaces: statistics in, rate result out, register writes.
// ----------------------------------------------------------------------------
interface rcpu_in_if;
  logic                               valid;
  logic                               ready;
  logic [rcpu_pkg::SUM_FIELD_W-1:0]   rtt_sum;
  logic [rcpu_pkg::CNT_FIELD_W-1:0]   rtt_count;
  logic [rcpu_pkg::BYTES_W-1:0]       input_bytes;
  logic [rcpu_pkg::QLEN_W-1:0]        queue_len;

  modport source (output valid, rtt_sum, rtt_count, input_bytes, queue_len,
                  input ready);
  modport sink   (input valid, rtt_sum, rtt_count, input_bytes, queue_len,
                  output ready);
endinterface

interface rcpu_out_if;
  logic                              valid;
  logic                              ready;
  logic [rcpu_pkg::RATE_W-1:0]       new_rate;
  logic [rcpu_pkg::CLIP_W-1:0]       clip_code;
  logic [rcpu_pkg::INTERVAL_W-1:0]   next_interval;
  logic [rcpu_pkg::AVG_W-1:0]        avg_rtt_out;

  modport source (output valid, new_rate, clip_code, next_interval, avg_rtt_out,
                  input ready);
  modport sink   (input valid, new_rate, clip_code, next_interval, avg_rtt_out,
                  output ready);
endinterface

interface rcpu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rcpu_pkg::CFG_IDX_W-1:0]    index;
  logic [rcpu_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rcpu_div.sv
// ----------------------------------------------------------------------------
// rcpu_div
// Radix-2 restoring divider: min(floor(num * 2^sh / den), QMAX), one bit
// per cycle.
// ----------------------------------------------------------------------------
module rcpu_div (
  input  logic               clk,
  input  logic               rst,
  input  rcpu_pkg::div_req_t req,
  output rcpu_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [rcpu_pkg::CNT_W-1:0]    cnt;
  logic [rcpu_pkg::QW-1:0]       dvd;
  logic [rcpu_pkg::QW-1:0]       den;
  logic [rcpu_pkg::QW-1:0]       rem;
  logic [rcpu_pkg::QW-1:0]       quo;
  logic                          ovf;

  logic [rcpu_pkg::QW:0]         trial;
  logic [rcpu_pkg::QW:0]         diff;
  logic                          qbit;
  logic [rcpu_pkg::QW-1:0]       rem_next;

  always_comb begin
    trial    = {rem, dvd[rcpu_pkg::QW-1]};
    diff     = trial - {1'b0, den};
    qbit     = (trial >= {1'b0, den});
    rem_next = qbit ? diff[rcpu_pkg::QW-1:0] : trial[rcpu_pkg::QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= rcpu_pkg::CNT_W'(rcpu_pkg::QW) + rcpu_pkg::CNT_W'(req.sh);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rcpu_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Payload: load operands, then shift one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.num;
      den <= req.den;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= rem_next;
      quo <= {quo[rcpu_pkg::QW-2:0], qbit};
      ovf <= ovf | quo[rcpu_pkg::QW-1];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = (ovf || quo > rcpu_pkg::QMAX) ? rcpu_pkg::QMAX : quo;

endmodule

// File: rtl/rcpu_mul.sv
// ----------------------------------------------------------------------------
// rcpu_mul
// Shift-add multiplier: full 128-bit product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rcpu_mul (
  input  logic               clk,
  input  logic               rst,
  input  rcpu_pkg::mul_req_t req,
  output rcpu_pkg::mul_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [rcpu_pkg::CNT_W-1:0]    cnt;
  logic [rcpu_pkg::QW-1:0]       mcand;
  logic [rcpu_pkg::QW-1:0]       mplier;
  logic [rcpu_pkg::QW-1:0]       hi;
  logic [rcpu_pkg::QW-1:0]       lo;
  logic [rcpu_pkg::QW:0]         psum;

  assign psum = {1'b0, hi} + (mplier[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= rcpu_pkg::CNT_W'(rcpu_pkg::QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == rcpu_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand  <= req.x;
      mplier <= req.y;
      hi     <= '0;
      lo     <= '0;
    end else if (busy) begin
      hi     <= psum[rcpu_pkg::QW:1];
      lo     <= {psum[0], lo[rcpu_pkg::QW-1:1]};
      mplier <= mplier >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = {hi, lo};

endmodule

// File: rtl/rcp_rate_update_core.sv
// ----------------------------------------------------------------------------
// rcp_rate_update_core
// RCP rate update: per control interval, average RTT with adaptive gain,
// rate equation, clipping and next interval, in Q.FRAC_BITS fixed point.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+----------
//  stats    | in  | rtt_sum, rtt_count, input_bytes, queue_len     | valid/ready
//  result   | out | new_rate, clip_code, next_interval, avg_rtt_out| valid/ready
//  cfg_wr   | in  | index, data                                    | valid/ready
//
//  One transaction on stats yields exactly one transaction on result.
//  An item runs as a sequence of operations on one radix-2 divider
//  and one shift-add multiplier; fewer operations run when the mean RTT
//  is not below the average. stats.ready is high only while the
//  sequencer is idle; a finished result waits in the output register
//  while the next transaction is taken. Synchronous active-high reset
//  restores control state, configuration and running state; cfg_wr is
//  always ready.
//
module rcp_rate_update_core (
  input  logic        clk,
  input  logic        rst,
  rcpu_in_if.sink     stats,
  rcpu_out_if.source  result,
  rcpu_cfg_if.sink    cfg_wr
);

  localparam int F  = rcpu_pkg::FRAC_BITS;
  localparam int QW = rcpu_pkg::QW;

  rcpu_pkg::cfg_t     cfg;
  rcpu_pkg::state_t   state, state_next;
  logic               issued, issued_next;

  rcpu_pkg::div_req_t div_req;
  rcpu_pkg::div_rsp_t div_rsp;
  rcpu_pkg::mul_req_t mul_req;
  rcpu_pkg::mul_rsp_t mul_rsp;

  // Running state.
  logic [rcpu_pkg::AVG_W-1:0]      avg_rtt;
  logic [rcpu_pkg::RATE_W-1:0]     current_rate;
  logic [rcpu_pkg::INTERVAL_W-1:0] interval_len;

  // Captured item and intermediate results.
  logic [QW-1:0]             in_sum, in_bytes;
  logic [31:0]               in_cnt, in_qlen;
  logic [31:0]               mean;
  logic [F:0]                r1, r2, r3, g1, g;
  logic [QW-1:0]             a_part;
  logic [rcpu_pkg::AVG_W-1:0] a;
  logic [QW-1:0]             vcap, d, qa, ta, ea, eb, p, x, temp, mp, minr;

  // Output register.
  logic                              out_valid;
  logic [rcpu_pkg::RATE_W-1:0]       out_rate;
  rcpu_pkg::clip_t                   out_code;
  logic [rcpu_pkg::INTERVAL_W-1:0]   out_interval;
  logic [rcpu_pkg::AVG_W-1:0]        out_avg;

  // Combinational helpers.
  logic [31:0]               a_old;
  logic [19:0]               cap_eff;
  logic [7:0]                ts_eff;
  logic [31:0]               mean_q;
  logic [QW-1:0]             a_sum, a_shift;
  logic [31:0]               a_calc;
  logic [QW-1:0]             vcap_calc, vd;
  logic                      epos, neg, tneg;
  logic [QW-1:0]             diff, e, e_sum;
  logic [QW-1:0]             fac;
  logic [QW-1:0]             clip_sel, rate_w, ts_shift, tq_sel;
  rcpu_pkg::clip_t           clip_calc;
  logic [rcpu_pkg::RATE_W-1:0]     rate_calc;
  logic [rcpu_pkg::INTERVAL_W-1:0] tq_calc;
  logic                      accept, load_out;

  rcpu_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  rcpu_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));

  assign accept       = stats.valid && stats.ready;
  assign stats.ready  = (state == rcpu_pkg::ST_IDLE);
  assign cfg_wr.ready = 1'b1;

  // Zero divisors and a zero timeslot act as one.
  assign a_old   = (avg_rtt == '0) ? 32'd1 : avg_rtt;
  assign cap_eff = (cfg.link_capacity == '0) ? 20'd1 : cfg.link_capacity;
  assign ts_eff  = (cfg.timeslot_ms == '0) ? 8'd1 : cfg.timeslot_ms;

  assign mean_q = (div_rsp.quo > rcpu_pkg::M32) ? 32'hFFFF_FFFF : div_rsp.quo[31:0];

  // New average: weighted sum of mean and old average, floored at one LSB.
  always_comb begin
    a_sum   = a_part + mul_rsp.prod[QW-1:0];
    a_shift = a_sum >> F;
    a_calc  = (a_shift[31:0] == '0) ? 32'd1 : a_shift[31:0];
  end

  assign vcap_calc = (mul_rsp.prod[QW-1:0] << F) >> 16;
  assign vd        = (vcap == '0) ? QW'(1) : vcap;

  // Error term sign and magnitude.
  always_comb begin
    epos  = (vcap >= d);
    diff  = epos ? (vcap - d) : (d - vcap);
    e_sum = ea + eb;
    if (epos) begin
      neg = (ea < eb);
      e   = neg ? (eb - ea) : (ea - eb);
    end else begin
      neg = 1'b1;
      e   = (e_sum > rcpu_pkg::QMAX) ? rcpu_pkg::QMAX : e_sum;
    end
  end

  // Rate factor 1 +/- x; below zero clips low.
  always_comb begin
    tneg = 1'b0;
    if (!neg) begin
      fac = rcpu_pkg::ONE + x;
    end else if (x <= rcpu_pkg::ONE) begin
      fac = rcpu_pkg::ONE - x;
    end else begin
      fac  = '0;
      tneg = 1'b1;
    end
  end

  // Clip: low test first, then high.
  always_comb begin
    if (tneg || temp < minr) begin
      clip_sel  = minr;
      clip_calc = rcpu_pkg::CLIP_LOW;
    end else if (temp > vcap) begin
      clip_sel  = vcap;
      clip_calc = rcpu_pkg::CLIP_HIGH;
    end else begin
      clip_sel  = temp;
      clip_calc = rcpu_pkg::CLIP_NONE;
    end
    rate_w = clip_sel >> F;
    if (rate_w == '0) begin
      rate_calc = 20'd1;
    end else if (rate_w > rcpu_pkg::M20) begin
      rate_calc = rcpu_pkg::M20[rcpu_pkg::RATE_W-1:0];
    end else begin
      rate_calc = rate_w[rcpu_pkg::RATE_W-1:0];
    end
    ts_shift = QW'(ts_eff) << F;
    tq_sel   = (QW'(a) < ts_shift) ? QW'(a) : ts_shift;
    tq_calc  = (tq_sel > rcpu_pkg::M24) ? rcpu_pkg::M24[rcpu_pkg::INTERVAL_W-1:0]
                                        : tq_sel[rcpu_pkg::INTERVAL_W-1:0];
  end

  assign load_out = (state == rcpu_pkg::ST_OUT) && (!out_valid || result.ready);

  // Sequencer: each operation state issues once and waits for the unit.
  always_comb begin
    state_next    = state;
    div_req       = '0;
    mul_req       = '0;
    unique case (state)
      rcpu_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (stats.rtt_count == '0) ? rcpu_pkg::ST_R3 : rcpu_pkg::ST_MEAN;
        end
      end
      rcpu_pkg::ST_MEAN: begin
        div_req = '{start: !issued, num: in_sum, den: QW'(in_cnt),
                    sh: rcpu_pkg::SH_W'(F)};
        if (div_rsp.done) state_next = rcpu_pkg::ST_R3;
      end
      rcpu_pkg::ST_R3: begin
        div_req = '{start: !issued, num: QW'(interval_len), den: QW'(a_old),
                    sh: rcpu_pkg::SH_W'(F)};
        if (div_rsp.done) begin
          state_next = (mean >= a_old) ? rcpu_pkg::ST_A1 : rcpu_pkg::ST_R1;
        end
      end
      rcpu_pkg::ST_R1: begin
        div_req = '{start: !issued, num: QW'(current_rate), den: QW'(cap_eff),
                    sh: rcpu_pkg::SH_W'(F)};
        if (div_rsp.done) state_next = rcpu_pkg::ST_R2;
      end
      rcpu_pkg::ST_R2: begin
        div_req = '{start: !issued, num: QW'(mean), den: QW'(a_old),
                    sh: rcpu_pkg::SH_W'(F)};
        if (div_rsp.done) state_next = rcpu_pkg::ST_G1;
      end
      rcpu_pkg::ST_G1: begin
        mul_req = '{start: !issued, x: QW'(r1), y: QW'(r2)};
        if (mul_rsp.done) state_next = rcpu_pkg::ST_G2;
      end
      rcpu_pkg::ST_G2: begin
        mul_req = '{start: !issued, x: QW'(g1), y: QW'(r3)};
        if (mul_rsp.done) state_next = rcpu_pkg::ST_A1;
      end
      rcpu_pkg::ST_A1: begin
        mul_req = '{start: !issued, x: QW'(g), y: QW'(mean)};
        if (mul_rsp.done) state_next = rcpu_pkg::ST_A2;
      end
      rcpu_pkg::ST_A2: begin
        mul_req = '{start: !issued, x: rcpu_pkg::ONE - QW'(g), y: QW'(a_old)};
        if (mul_rsp.done) state_next = rcpu_pkg::ST_VCAP;
      end
      rcpu_pkg::ST_VCAP: begin
        mul_req = '{start: !issued, x: QW'(cfg.gamma_gain), y: QW'(cfg.link_capacity)};
        if (mul_rsp.done) state_next = rcpu_pkg::ST_D;
      end
      rcpu_pkg::ST_D: begin
        div_req = '{start: !issued, num: in_bytes, den: QW'(interval_len),
                    sh: rcpu_pkg::SH_W'(2 * F)};
        if (div_rsp.done) state_next = rcpu_pkg::ST_QA;
      end
      rcpu_pkg::ST_QA: begin
        div_req = '{start: !issued, num: QW'(in_qlen), den: QW'(a),
                    sh: rcpu_pkg::SH_W'(2 * F)};
        if (div_rsp.done) state_next = rcpu_pkg::ST_TA;
      end
      rcpu_pkg::ST_TA: begin
        div_req = '{start: !issued, num: QW'(interval_len), den: QW'(a),
                    sh: rcpu_pkg::SH_W'(F)};
        if (div_rsp.done) state_next = rcpu_pkg::ST_EA;
      end
      rcpu_pkg::ST_EA: begin
        mul_req = '{start: !issued, x: diff, y: QW'(cfg.alpha_gain)};
        if (mul_rsp.done) state_next = rcpu_pkg::ST_EB;
      end
      rcpu_pkg::ST_EB: begin
        mul_req = '{start: !issued, x: qa, y: QW'(cfg.beta_gain)};
        if (mul_rsp.done) state_next = rcpu_pkg::ST_P;
      end
      rcpu_pkg::ST_P: begin
        mul_req = '{start: !issued, x: e, y: ta};
        if (mul_rsp.done) state_next = rcpu_pkg::ST_X;
      end
      rcpu_pkg::ST_X: begin
        div_req = '{start: !issued, num: p, den: vd, sh: rcpu_pkg::SH_W'(F)};
        if (div_rsp.done) state_next = rcpu_pkg::ST_TEMP;
      end
      rcpu_pkg::ST_TEMP: begin
        // Skip the product when the factor is negative or saturates.
        if (tneg || fac > rcpu_pkg::FAC_LIM) begin
          state_next = rcpu_pkg::ST_MP;
        end else begin
          mul_req = '{start: !issued, x: QW'(current_rate), y: fac};
          if (mul_rsp.done) state_next = rcpu_pkg::ST_MP;
        end
      end
      rcpu_pkg::ST_MP: begin
        mul_req = '{start: !issued, x: QW'(cfg.min_pkts_per_rtt),
                    y: QW'(cfg.packet_size)};
        if (mul_rsp.done) state_next = rcpu_pkg::ST_MINR;
      end
      rcpu_pkg::ST_MINR: begin
        div_req = '{start: !issued, num: mp, den: QW'(a),
                    sh: rcpu_pkg::SH_W'(2 * F - 16)};
        if (div_rsp.done) state_next = rcpu_pkg::ST_OUT;
      end
      rcpu_pkg::ST_OUT: begin
        if (load_out) state_next = rcpu_pkg::ST_IDLE;
      end
      default: state_next = rcpu_pkg::ST_IDLE;
    endcase

    if (div_rsp.done || mul_rsp.done) begin
      issued_next = 1'b0;
    end else if (div_req.start || mul_req.start) begin
      issued_next = 1'b1;
    end else begin
      issued_next = issued;
    end
  end

  // Control state, configuration and running state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcpu_pkg::ST_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      cfg.link_capacity    <= 20'd125000;
      cfg.alpha_gain       <= 16'd26214;
      cfg.beta_gain        <= 16'd32768;
      cfg.gamma_gain       <= 16'd62259;
      cfg.min_pkts_per_rtt <= 24'd6554;
      cfg.packet_size      <= 16'd1500;
      cfg.timeslot_ms      <= 8'd10;
      avg_rtt      <= rcpu_pkg::AVG_RESET;
      current_rate <= rcpu_pkg::RATE_RESET;
      interval_len <= rcpu_pkg::INT_RESET;
    end else begin
      state  <= state_next;
      issued <= issued_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        // Commit the running state with the result.
        avg_rtt      <= a;
        current_rate <= rate_calc;
        interval_len <= tq_calc;
      end
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          rcpu_pkg::CFG_LINK_CAPACITY: cfg.link_capacity    <= cfg_wr.data[19:0];
          rcpu_pkg::CFG_ALPHA_GAIN:    cfg.alpha_gain       <= cfg_wr.data[15:0];
          rcpu_pkg::CFG_BETA_GAIN:     cfg.beta_gain        <= cfg_wr.data[15:0];
          rcpu_pkg::CFG_GAMMA_GAIN:    cfg.gamma_gain       <= cfg_wr.data[15:0];
          rcpu_pkg::CFG_MIN_PKTS:      cfg.min_pkts_per_rtt <= cfg_wr.data[23:0];
          rcpu_pkg::CFG_PACKET_SIZE:   cfg.packet_size      <= cfg_wr.data[15:0];
          rcpu_pkg::CFG_TIMESLOT_MS:   cfg.timeslot_ms      <= cfg_wr.data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath captures: hold each operation's result as its unit finishes.
  always_ff @(posedge clk) begin
    unique case (state)
      rcpu_pkg::ST_IDLE: begin
        if (accept) begin
          in_sum   <= QW'(stats.rtt_sum) & rcpu_pkg::SUM_MASK;
          in_bytes <= QW'(stats.input_bytes) & rcpu_pkg::SUM_MASK;
          in_cnt   <= stats.rtt_count;
          in_qlen  <= stats.queue_len;
          mean     <= '0;
        end
      end
      rcpu_pkg::ST_MEAN: if (div_rsp.done) mean <= mean_q;
      rcpu_pkg::ST_R3: begin
        if (div_rsp.done) begin
          r3 <= rcpu_pkg::cap1(div_rsp.quo);
          g  <= rcpu_pkg::cap1(div_rsp.quo);
        end
      end
      rcpu_pkg::ST_R1: if (div_rsp.done) r1 <= rcpu_pkg::cap1(div_rsp.quo);
      rcpu_pkg::ST_R2: if (div_rsp.done) r2 <= rcpu_pkg::cap1(div_rsp.quo);
      rcpu_pkg::ST_G1: if (mul_rsp.done) g1 <= mul_rsp.prod[F +: F + 1];
      rcpu_pkg::ST_G2: if (mul_rsp.done) g  <= mul_rsp.prod[F +: F + 1];
      rcpu_pkg::ST_A1: if (mul_rsp.done) a_part <= mul_rsp.prod[QW-1:0];
      rcpu_pkg::ST_A2: if (mul_rsp.done) a <= a_calc;
      rcpu_pkg::ST_VCAP: if (mul_rsp.done) vcap <= vcap_calc;
      rcpu_pkg::ST_D:  if (div_rsp.done) d  <= div_rsp.quo;
      rcpu_pkg::ST_QA: if (div_rsp.done) qa <= div_rsp.quo;
      rcpu_pkg::ST_TA: if (div_rsp.done) ta <= div_rsp.quo;
      rcpu_pkg::ST_EA: if (mul_rsp.done) ea <= rcpu_pkg::sat_shr(mul_rsp.prod, 16);
      rcpu_pkg::ST_EB: if (mul_rsp.done) eb <= rcpu_pkg::sat_shr(mul_rsp.prod, 16);
      rcpu_pkg::ST_P:  if (mul_rsp.done) p  <= rcpu_pkg::sat_shr(mul_rsp.prod, F);
      rcpu_pkg::ST_X:  if (div_rsp.done) x  <= div_rsp.quo;
      rcpu_pkg::ST_TEMP: begin
        if (!tneg && fac > rcpu_pkg::FAC_LIM) begin
          temp <= rcpu_pkg::QMAX;
        end else if (mul_rsp.done) begin
          temp <= mul_rsp.prod[QW-1:0];
        end
      end
      rcpu_pkg::ST_MP:   if (mul_rsp.done) mp   <= mul_rsp.prod[QW-1:0];
      rcpu_pkg::ST_MINR: if (div_rsp.done) minr <= div_rsp.quo;
      rcpu_pkg::ST_OUT: begin
        if (load_out) begin
          out_rate     <= rate_calc;
          out_code     <= clip_calc;
          out_interval <= tq_calc;
          out_avg      <= a;
        end
      end
      default: ;
    endcase
  end

  assign result.valid         = out_valid;
  assign result.new_rate      = out_rate;
  assign result.clip_code     = out_code;
  assign result.next_interval = out_interval;
  assign result.avg_rtt_out   = out_avg;

endmodule

// File: rtl/rcpu_chk.sv
// ----------------------------------------------------------------------------
// rcpu_chk
// Port-level checks of the RCP rate update core, bound to the top level.
// ----------------------------------------------------------------------------
module rcpu_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [rcpu_pkg::RATE_W-1:0]         new_rate,
  input logic [rcpu_pkg::CLIP_W-1:0]         clip_code,
  input logic [rcpu_pkg::INTERVAL_W-1:0]     next_interval,
  input logic [rcpu_pkg::AVG_W-1:0]          avg_rtt_out
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_rate) &&
      $stable(clip_code) && $stable(next_interval) && $stable(avg_rtt_out))
    else $error("result changed while stalled");

  // One item at a time: an accepted transaction closes the input.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // Rate floored at one, code valid, average never zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> new_rate != '0 && avg_rtt_out != '0 &&
      (clip_code == rcpu_pkg::CLIP_LOW || clip_code == rcpu_pkg::CLIP_HIGH ||
       clip_code == rcpu_pkg::CLIP_NONE))
    else $error("result out of range");

  // Next interval never exceeds the new average.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rcpu_pkg::AVG_W'(next_interval) <= avg_rtt_out)
    else $error("next interval above average RTT");

endmodule

bind rcp_rate_update_core rcpu_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (stats.valid),
  .in_ready      (stats.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .new_rate      (result.new_rate),
  .clip_code     (result.clip_code),
  .next_interval (result.next_interval),
  .avg_rtt_out   (result.avg_rtt_out)
);
